// ----- hw/rtl/cmf_pkg.sv -----
// Shared types and constants of the cross morphology filter.
package cmf_pkg;

  // Defaults for the structural parameters of the top level.
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_OFFSET    = 2;

  // Field and register widths.
  localparam int PIX_W    = 8;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 12;
  localparam int ROW_W    = HEIGHT_W + 1;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD = 2'd2;

  // Register values after reset.
  localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH    = 11'd640;
  localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT   = 12'd480;
  localparam logic [PIX_W-1:0]    RST_DARK_THRESHOLD = 8'd127;

  // Output pixel levels.
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             frame_start;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             frame_last;
  } out_word_t;

  // Per-item control handed from the position unit to the result stage.
  typedef struct packed {
    logic has_result;  // the item's row is far enough down to emit a pixel
    logic frame_last;  // last result of the frame
    logic bypass;      // the south neighbour is the mark written by this item
    logic dark;        // the mark written by this item
  } pos_info_t;

endpackage

// ----- hw/rtl/cross_morphology_filter_top.sv -----
// Top level of the cross morphology filter: registers, pipeline and store.
//
// Grayscale pixels enter on the in channel in raster order, one word per
// pixel, followed by OFFSET flush rows of image_width words each. Each pixel
// is marked dark when its value is below dark_threshold. The out channel
// carries one word for every input word of row OFFSET and below: the pixel
// OFFSET rows above it, 0 when any of its four cross neighbours at distance
// OFFSET is dark and 255 otherwise; frame_last flags the final word.
// The in and out channels use valid/ready handshakes; the configuration
// port is a plain write port, to be written only while the filter is idle;
// the block does not enforce this. Throughput is one word per clock while
// the receiver does not stall. A word accepted into the input register
// has its line store read into the read stage and its result put into
// the output register. The marks live in two copies of a (2*OFFSET+1)-row
// line store so that all four neighbours are read in the same cycle.
// When the receiver stalls, the output register holds its word. Words still
// move into the read stage and the input register while they are empty, and
// in_ready drops as soon as both are full, in the same cycle as out_ready
// when the pipeline is already full. Reset clears the position counters and
// the valid flags and loads the register defaults; the store is not cleared.
module cross_morphology_filter_top #(
  parameter int MAX_WIDTH = cmf_pkg::DEF_MAX_WIDTH,
  parameter int OFFSET    = cmf_pkg::DEF_OFFSET
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cmf_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cmf_pkg::out_word_t             out_word,
  input  logic                           cfg_wr_en,
  input  logic [cmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cmf_pkg::CFG_W-1:0]      cfg_data
);

  localparam int RING  = 2 * OFFSET + 1;
  localparam int DEPTH = RING * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers.
  logic [cmf_pkg::WIDTH_W-1:0]  image_width;
  logic [cmf_pkg::HEIGHT_W-1:0] image_height;
  logic [cmf_pkg::PIX_W-1:0]    dark_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= cmf_pkg::RST_IMAGE_WIDTH;
      image_height   <= cmf_pkg::RST_IMAGE_HEIGHT;
      dark_threshold <= cmf_pkg::RST_DARK_THRESHOLD;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cmf_pkg::REG_IMAGE_WIDTH:    image_width    <= cfg_data[cmf_pkg::WIDTH_W-1:0];
        cmf_pkg::REG_IMAGE_HEIGHT:   image_height   <= cfg_data[cmf_pkg::HEIGHT_W-1:0];
        cmf_pkg::REG_DARK_THRESHOLD: dark_threshold <= cfg_data[cmf_pkg::PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Stage enables: each stage moves when the one after it has room.
  logic s1_valid, s2_valid;
  logic s1_en, s2_en, out_en, step;
  cmf_pkg::in_word_t  s1_word;
  cmf_pkg::pos_info_t pos_info, s2_info;

  assign out_en   = !out_valid || out_ready;
  assign s2_en    = !s2_valid || out_en;
  assign s1_en    = !s1_valid || s2_en;
  assign in_ready = s1_en;
  assign step     = s1_valid && s2_en;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_word <= in_word;
    end
  end

  // Position counters and store addresses for the word in the input register.
  logic          wr_en, wr_data;
  logic [AW-1:0] wr_addr, rd_addr_north, rd_addr_south, rd_addr_east, rd_addr_west;

  cmf_pos #(
    .MAX_WIDTH (MAX_WIDTH),
    .OFFSET    (OFFSET)
  ) u_pos (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .word           (s1_word),
    .image_width    (image_width),
    .image_height   (image_height),
    .dark_threshold (dark_threshold),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_addr_north  (rd_addr_north),
    .rd_addr_south  (rd_addr_south),
    .rd_addr_east   (rd_addr_east),
    .rd_addr_west   (rd_addr_west),
    .info           (pos_info)
  );

  // Two identical copies of the line store give four reads per cycle.
  logic dark_north, dark_south_mem, dark_east, dark_west, dark_south, dark_any;

  cmf_mem #(.DEPTH(DEPTH)) u_mem_ns (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (step),
    .rd_addr_a (rd_addr_north),
    .rd_addr_b (rd_addr_south),
    .rd_data_a (dark_north),
    .rd_data_b (dark_south_mem)
  );

  cmf_mem #(.DEPTH(DEPTH)) u_mem_ew (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (step),
    .rd_addr_a (rd_addr_east),
    .rd_addr_b (rd_addr_west),
    .rd_data_a (dark_east),
    .rd_data_b (dark_west)
  );

  // Store read stage. The south neighbour can be the very mark written in
  // the same cycle, which the store does not return yet, so it is forwarded.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid && pos_info.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s2_info <= pos_info;
    end
  end

  assign dark_south = s2_info.bypass ? s2_info.dark : dark_south_mem;
  assign dark_any   = dark_north || dark_south || dark_east || dark_west;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s2_valid) begin
      out_word.out_pixel  <= dark_any ? cmf_pkg::PIX_BLACK : cmf_pkg::PIX_WHITE;
      out_word.frame_last <= s2_info.frame_last;
    end
  end

endmodule

// ----- hw/rtl/cmf_mem.sv -----
// Line store of dark marks: one write port, two registered read ports.
module cmf_mem #(
  parameter int DEPTH = 5 * cmf_pkg::DEF_MAX_WIDTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic          rd_data_a,
  output logic          rd_data_b
);

  logic mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ----- hw/rtl/cmf_pos.sv -----
// Raster position counters and line store address generation.
module cmf_pos #(
  parameter int MAX_WIDTH = cmf_pkg::DEF_MAX_WIDTH,
  parameter int OFFSET    = cmf_pkg::DEF_OFFSET,
  localparam int RING     = 2 * OFFSET + 1,
  localparam int AW       = $clog2(RING * MAX_WIDTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  cmf_pkg::in_word_t             word,
  input  logic [cmf_pkg::WIDTH_W-1:0]   image_width,
  input  logic [cmf_pkg::HEIGHT_W-1:0]  image_height,
  input  logic [cmf_pkg::PIX_W-1:0]     dark_threshold,
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output logic                          wr_data,
  output logic [AW-1:0]                 rd_addr_north,
  output logic [AW-1:0]                 rd_addr_south,
  output logic [AW-1:0]                 rd_addr_east,
  output logic [AW-1:0]                 rd_addr_west,
  output cmf_pkg::pos_info_t            info
);

  localparam int SLOT_W = $clog2(RING);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = cmf_pkg::ROW_W;
  localparam int HW     = cmf_pkg::HEIGHT_W;
  localparam logic [SLOT_W:0]   RING_V = (SLOT_W + 1)'(RING);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING - 1);

  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [SLOT_W-1:0] slot, slot_next;

  logic [WW-1:0]     w_eff, w_m_off;
  logic [HW-1:0]     h_eff;
  logic [ROW_W-1:0]  total_rows, h_m_off, dp_full;
  logic [COL_W-1:0]  x;
  logic [ROW_W-1:0]  y;
  logic [SLOT_W-1:0] s, d_p, d_m, s_off;
  logic [WW-1:0]     xm_raw, xm_cl;
  logic [WW:0]       xp_raw;
  logic [COL_W-1:0]  xm, xp;
  logic [WW-1:0]     x_inc;
  logic              dark;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] a);
    return (a == LAST_SLOT) ? '0 : a + SLOT_W'(1);
  endfunction

  // Slot of the row that lies d rows above the row in slot a.
  function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] a,
                                                  input logic [SLOT_W-1:0] d);
    logic [SLOT_W:0] t;
    t = {1'b0, a} + RING_V - {1'b0, d};
    if (t >= RING_V) begin
      t = t - RING_V;
    end
    return t[SLOT_W-1:0];
  endfunction

  function automatic logic [AW-1:0] store_addr(input logic [SLOT_W-1:0] a,
                                               input logic [COL_W-1:0]  c);
    return AW'(a) * AW'(MAX_WIDTH) + AW'(c);
  endfunction

  // Effective geometry.
  always_comb begin
    if (32'(image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else if (32'(image_width) < OFFSET) begin
      w_eff = WW'(OFFSET);
    end else begin
      w_eff = WW'(image_width);
    end
    h_eff      = (image_height < HW'(OFFSET)) ? HW'(OFFSET) : image_height;
    total_rows = ROW_W'(h_eff) + ROW_W'(OFFSET);
    w_m_off    = w_eff - WW'(OFFSET);
    h_m_off    = ROW_W'(h_eff) - ROW_W'(OFFSET);
  end

  // Position of the current item.
  always_comb begin
    x = word.frame_start ? '0 : col;
    y = word.frame_start ? '0 : row;
    s = word.frame_start ? '0 : slot;
    if (WW'(x) >= w_eff) begin
      x = '0;
      y = y + ROW_W'(1);
      s = slot_inc(s);
    end
    if (y >= total_rows) begin
      y = '0;
      s = '0;
    end
  end

  // Neighbour rows and columns, clamped to the frame.
  always_comb begin
    dp_full = (y > h_m_off) ? y - h_m_off : '0;
    d_p     = SLOT_W'(dp_full);
    d_m     = (y < ROW_W'(2 * OFFSET)) ? SLOT_W'(y) : SLOT_W'(2 * OFFSET);
    s_off   = slot_back(s, SLOT_W'(OFFSET));

    xm_raw = (WW'(x) < WW'(OFFSET)) ? '0 : WW'(x) - WW'(OFFSET);
    xm_cl  = (xm_raw > w_m_off) ? w_m_off : xm_raw;
    xm     = COL_W'(xm_cl);
    xp_raw = (WW + 1)'(x) + (WW + 1)'(OFFSET);
    xp     = (xp_raw > {1'b0, w_m_off}) ? COL_W'(w_m_off) : COL_W'(xp_raw);
  end

  always_comb begin
    dark          = word.pixel_value < dark_threshold;
    wr_en         = step && (y < ROW_W'(h_eff));
    wr_addr       = store_addr(s, x);
    wr_data       = dark;
    rd_addr_north = store_addr(slot_back(s, d_m), x);
    rd_addr_south = store_addr(slot_back(s, d_p), x);
    rd_addr_east  = store_addr(s_off, xp);
    rd_addr_west  = store_addr(s_off, xm);

    info.has_result = y >= ROW_W'(OFFSET);
    info.frame_last = (WW'(x) == w_eff - WW'(1)) && (y == total_rows - ROW_W'(1));
    info.bypass     = d_p == '0;
    info.dark       = dark;
  end

  // Position of the next item.
  always_comb begin
    x_inc     = WW'(x) + WW'(1);
    col_next  = COL_W'(x_inc);
    row_next  = y;
    slot_next = s;
    if (x_inc >= w_eff) begin
      col_next  = '0;
      row_next  = y + ROW_W'(1);
      slot_next = slot_inc(s);
      if (row_next >= total_rows) begin
        row_next  = '0;
        slot_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      slot <= '0;
    end else if (step) begin
      col  <= col_next;
      row  <= row_next;
      slot <= slot_next;
    end
  end

endmodule

// ----- bench/tb_cross_morphology_filter_top.sv -----
// Self-checking testbench of the cross morphology filter top level.
module tb_cross_morphology_filter_top;

  // Geometry of the line store, as built into the default top level.
  localparam int MAXW = cmf_pkg::DEF_MAX_WIDTH;
  localparam int OFF  = cmf_pkg::DEF_OFFSET;
  localparam int RING = 2 * OFF + 1;

  // Cycles to let pass once every expected word has arrived, so that items
  // of the first rows of a frame, which give no word, have left the pipeline.
  localparam int PIPE_SETTLE = 8;

  // Length of the one long receiver hold-off that fills the pipeline.
  localparam int HOLD_OFF_CYCLES = 300;

  // Cycles without any accepted word on either channel before the run is
  // declared hung. The longest correct quiet stretch is the hold-off above.
  localparam int WATCHDOG_LIMIT = 2000;

  // Input words of the random part, on top of the directed phases.
  localparam int RANDOM_ITEMS = 200;

  // The scoreboard keeps its own copy of the registers, the position counters
  // and the dark marks, and predicts every output word from the accepted pixels.
  class cross_filter_scoreboard;
    bit                  marks [RING*MAXW];
    int unsigned         col;
    int unsigned         row;
    int unsigned         reg_w;
    int unsigned         reg_h;
    int unsigned         reg_thr;
    cmf_pkg::out_word_t  pending_pixels [$];
    int unsigned         failures;

    function new();
      col      = 0;
      row      = 0;
      reg_w    = cmf_pkg::RST_IMAGE_WIDTH;
      reg_h    = cmf_pkg::RST_IMAGE_HEIGHT;
      reg_thr  = cmf_pkg::RST_DARK_THRESHOLD;
      failures = 0;
    endfunction

    function void write_reg(logic [cmf_pkg::CFG_IDX_W-1:0] idx,
                            logic [cmf_pkg::CFG_W-1:0] data);
      case (idx)
        cmf_pkg::REG_IMAGE_WIDTH:    reg_w   = data[cmf_pkg::WIDTH_W-1:0];
        cmf_pkg::REG_IMAGE_HEIGHT:   reg_h   = data[cmf_pkg::HEIGHT_W-1:0];
        cmf_pkg::REG_DARK_THRESHOLD: reg_thr = data[cmf_pkg::PIX_W-1:0];
        default: ;
      endcase
    endfunction

    function bit mark_at(int unsigned c, int unsigned r);
      return marks[(r % RING) * MAXW + (c % MAXW)];
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    // Advances the position for one accepted input word, stores its mark and
    // queues the filtered pixel OFFSET rows above it, when there is one.
    function void note_pixel(cmf_pkg::in_word_t word);
      int unsigned        w, h, rows, x, y, yo, xm, xp, ym, yp;
      bit                 dark_any;
      cmf_pkg::out_word_t res;
      w = reg_w;
      if (w > MAXW) w = MAXW;
      if (w < OFF) w = OFF;
      h = reg_h;
      if (h < OFF) h = OFF;
      rows = h + OFF;
      if (word.frame_start) begin
        col = 0;
        row = 0;
      end
      if (col >= w) begin
        col = 0;
        row++;
      end
      if (row >= rows) row = 0;
      x = col;
      y = row;
      if (y < h) marks[(y % RING) * MAXW + x] = (word.pixel_value < reg_thr);
      if (y >= OFF) begin
        yo = y - OFF;
        xm = (x < OFF) ? 0 : x - OFF;
        if (xm > w - OFF) xm = w - OFF;
        xp = x + OFF;
        if (xp > w - OFF) xp = w - OFF;
        ym = (yo < OFF) ? 0 : yo - OFF;
        if (ym > h - OFF) ym = h - OFF;
        yp = yo + OFF;
        if (yp > h - OFF) yp = h - OFF;
        dark_any = mark_at(x, yp) || mark_at(xp, yo) || mark_at(x, ym) || mark_at(xm, yo);
        res.out_pixel  = dark_any ? cmf_pkg::PIX_BLACK : cmf_pkg::PIX_WHITE;
        res.frame_last = (x == w - 1) && (y == rows - 1);
        pending_pixels.push_back(res);
      end
      col = x + 1;
      if (col >= w) begin
        col = 0;
        row = y + 1;
        if (row >= rows) row = 0;
      end
    endfunction

    // Compares one accepted output word with the oldest prediction.
    function void check_word(cmf_pkg::out_word_t got);
      cmf_pkg::out_word_t want;
      if (pending_pixels.size() == 0) begin
        $error("unexpected output word: out_pixel %0d frame_last %0d",
               got.out_pixel, got.frame_last);
        failures++;
        return;
      end
      want = pending_pixels.pop_front();
      if (got.out_pixel !== want.out_pixel) begin
        $error("out_pixel: expected %0d, actual %0d", want.out_pixel, got.out_pixel);
        failures++;
      end
      if (got.frame_last !== want.frame_last) begin
        $error("frame_last: expected %0d, actual %0d", want.frame_last, got.frame_last);
        failures++;
      end
    endfunction
  endclass

  // Every input of the block has a known value from time zero on.
  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  cmf_pkg::in_word_t             in_word   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  cmf_pkg::out_word_t            out_word;
  logic                          cfg_wr_en = 1'b0;
  logic [cmf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cmf_pkg::CFG_W-1:0]     cfg_data  = '0;

  cross_filter_scoreboard sb;

  // Register values as last written, used to shape the stimulus.
  int unsigned cur_w   = cmf_pkg::RST_IMAGE_WIDTH;
  int unsigned cur_h   = cmf_pkg::RST_IMAGE_HEIGHT;
  int unsigned cur_thr = cmf_pkg::RST_DARK_THRESHOLD;

  // Per-phase switches for the random gaps on each side, and the request for
  // the one long hold-off of the receiver.
  bit tx_idle_on      = 1'b1;
  bit rx_idle_on      = 1'b1;
  bit hold_off_request = 1'b0;

  int unsigned quiet_cycles = 0;

  always #10 clk = ~clk;

  cross_morphology_filter_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Draws a pixel that is dark with the given percentage under the current
  // threshold. The values right at the threshold and the field extremes come
  // up often, since that is where the compare can go wrong.
  function automatic logic [cmf_pkg::PIX_W-1:0] draw_pixel(int dark_pct, int unsigned thr);
    int unsigned pick;
    pick = $urandom_range(0, 3);
    if (thr > 0 && $urandom_range(0, 99) < dark_pct) begin
      case (pick)
        0:       return '0;
        1:       return cmf_pkg::PIX_W'(thr - 1);
        default: return cmf_pkg::PIX_W'($urandom_range(0, thr - 1));
      endcase
    end else begin
      case (pick)
        0:       return cmf_pkg::PIX_WHITE;
        1:       return cmf_pkg::PIX_W'(thr);
        default: return cmf_pkg::PIX_W'($urandom_range(thr, 255));
      endcase
    end
  endfunction

  // Offers one input word after a random gap and holds it until accepted.
  // The scoreboard learns of the word at the edge that takes it.
  task automatic send_word(cmf_pkg::in_word_t word);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= word;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(word);
  endtask

  // Sends a run of pixels. The first one may open a frame; restart_pm is the
  // chance per thousand that any word raises frame_start in mid-frame.
  task automatic run_phase(int unsigned n_items, bit start_frame, int dark_pct,
                           int unsigned restart_pm);
    cmf_pkg::in_word_t word;
    for (int unsigned i = 0; i < n_items; i++) begin
      word.pixel_value = draw_pixel(dark_pct, cur_thr);
      word.frame_start = (i == 0 && start_frame) || ($urandom_range(0, 999) < restart_pm);
      send_word(word);
    end
  endtask

  // Stops offering, waits for every predicted word, then lets the tail of
  // the pipeline run empty so that register writes land on an idle block.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [cmf_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= cmf_pkg::CFG_W'(value);
    @(posedge clk);
    sb.write_reg(idx, cmf_pkg::CFG_W'(value));
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned thr);
    write_reg(cmf_pkg::REG_IMAGE_WIDTH, w);
    write_reg(cmf_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(cmf_pkg::REG_DARK_THRESHOLD, thr);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_w   = w;
    cur_h   = h;
    cur_thr = thr;
  endtask

  // Receiver: takes output words with random stalls. Once, on request, it
  // holds ready low for a long stretch so that the pipeline fills and the
  // block has to stall its input while the sender keeps offering words.
  initial begin
    int unsigned gap;
    wait (rst == 1'b0);
    forever begin
      gap = rx_idle_on ? $urandom_range(0, 5) : 0;
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        gap = HOLD_OFF_CYCLES;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_word(out_word);
    end
  end

  // Watchdog: a hung handshake on either side ends the run as a failure.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Main sequence: directed phases first, then random frames.
  initial begin
    int unsigned w, h, thr, n, frame_len, sent;
    bit          fresh;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Register defaults straight out of reset: the first row of a 640-wide
    // frame gives no word, so these pixels must pass without any output.
    run_phase(40, 1'b1, 15, 0);

    // Small frame that keeps the default threshold.
    settle();
    write_reg(cmf_pkg::REG_IMAGE_WIDTH, 6);
    write_reg(cmf_pkg::REG_IMAGE_HEIGHT, 5);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_w = 6;
    cur_h = 5;
    run_phase(2 * 6 * (5 + OFF), 1'b1, 15, 0);

    // A 4x4 frame with a zero threshold, so that nothing is dark. The
    // second frame follows with no frame_start and relies on the wrap at
    // the end of the flush rows.
    settle();
    configure(4, 4, 0);
    run_phase(2 * 4 * (4 + OFF), 1'b1, 30, 0);

    // Threshold at its top: only a white pixel stays light.
    settle();
    configure(5, 4, 255);
    run_phase(2 * 5 * (4 + OFF), 1'b1, 10, 0);

    // Width and height below range saturate to the smallest effective frame.
    settle();
    configure(1, 0, 128);
    run_phase(3 * OFF * (OFF + OFF), 1'b1, 30, 0);

    // Width above range saturates to the full line store, so these pixels
    // all stay in the first row and give no word.
    settle();
    configure(2047, 4, 60);
    run_phase(100, 1'b1, 5, 0);

    // Start of a 2048-row frame, sent with no gaps on either side, with
    // the long receiver hold-off falling somewhere inside it.
    settle();
    configure(4, 2048, 100);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_off_request = 1'b1;
    run_phase(4 * 30, 1'b1, 10, 0);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    // Width shrunk in mid-frame while the column is already past it: the
    // position has to move on to the next row.
    settle();
    configure(12, 10, 127);
    run_phase(5 * 12 + 7, 1'b1, 10, 0);
    settle();
    configure(6, 10, 127);
    run_phase(100, 1'b0, 10, 0);

    // Height shrunk in mid-frame below the current row: back to row 0.
    settle();
    configure(8, 12, 127);
    run_phase(9 * 8, 1'b1, 10, 0);
    settle();
    configure(8, 5, 127);
    run_phase(60, 1'b0, 10, 0);

    // Height shrunk so that the current row becomes a flush row.
    settle();
    configure(8, 12, 127);
    run_phase(7 * 8, 1'b1, 10, 0);
    settle();
    configure(8, 6, 127);
    run_phase(80, 1'b0, 10, 0);

    // A frame cut short by the frame_start of the next one.
    settle();
    configure(10, 6, 90);
    run_phase(35, 1'b1, 10, 0);
    run_phase(10 * (6 + OFF), 1'b1, 10, 0);

    // Random part. Most phases open a new frame with a fresh geometry; the
    // rest go on with the frame in progress, where the geometry may only
    // shrink so that no mark is read that was never written.
    sent  = 0;
    fresh = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      settle();
      if (fresh || $urandom_range(0, 3) != 0) begin
        fresh = 1'b1;
        w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(4, 16);
        h = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : $urandom_range(4, 10);
      end else begin
        w = $urandom_range(4, cur_w);
        h = $urandom_range(4, cur_h);
      end
      case ($urandom_range(0, 5))
        0:       thr = 0;
        1:       thr = 255;
        default: thr = $urandom_range(1, 254);
      endcase
      configure(w, h, thr);
      frame_len = w * (h + OFF);
      case ($urandom_range(0, 2))
        0:       n = frame_len;
        1:       n = 2 * frame_len;
        default: n = $urandom_range(1, 2 * frame_len);
      endcase
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      run_phase(n, fresh, $urandom_range(2, 40), ($urandom_range(0, 3) == 0) ? 10 : 0);
      sent += n;
      fresh = 1'b0;
    end

    settle();
    if (sb.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/cmf_pkg.sv
hw/rtl/cmf_mem.sv
hw/rtl/cmf_pos.sv
hw/rtl/cross_morphology_filter_top.sv
bench/tb_cross_morphology_filter_top.sv
